// ===== hw/rtl/dqu_pkg.sv =====
// Shared constants and types for the double-ended queue unit.
package dqu_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [2:0] ACT_PUSH_HEAD = 3'd0;
  localparam logic [2:0] ACT_PUSH_TAIL = 3'd1;
  localparam logic [2:0] ACT_POP_HEAD  = 3'd2;
  localparam logic [2:0] ACT_POP_TAIL  = 3'd3;
  localparam logic [2:0] ACT_POP_INDEX = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load_op;
    logic exec;
  } dqu_cmd_t;

endpackage

// ===== hw/rtl/dqu_ctrl.sv =====
// Controller state machine that sequences operand capture and execution.
module dqu_ctrl import dqu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dqu_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_op = in_valid;
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dqu_dp.sv =====
// Datapath holding the entry store, the occupancy and the result register.
module dqu_dp import dqu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dqu_cmd_t              cmd,
  input  logic [2:0]            action,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [IDX_W-1:0]      index,
  output logic [DATA_WIDTH-1:0] value_out,
  output logic [1:0]            status,
  output logic [CNT_W-1:0]      count
);

  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [DATA_WIDTH-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0]      occupancy;
  logic [CNT_W-1:0]      occupancy_next;
  logic [2:0]            op_action;
  logic [DATA_WIDTH-1:0] op_value;
  logic [IDX_W-1:0]      op_index;
  logic [DATA_WIDTH-1:0] popped;
  logic [1:0]            stat;
  logic [IDX_W-1:0]      rm_pos;
  logic                  shift_up;
  logic                  shift_down;
  logic                  wr_head;
  logic                  full;
  logic                  empty;

  assign full  = (occupancy == CNT_W'(DEPTH));
  assign empty = (occupancy == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.exec) begin
      occupancy <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_action <= action;
      op_value  <= value;
      op_index  <= index;
    end
    if (cmd.exec) begin
      entries   <= entries_next;
      value_out <= popped;
      status    <= stat;
      count     <= occupancy_next;
    end
  end

  always_comb begin
    shift_up       = 1'b0;
    shift_down     = 1'b0;
    wr_head        = 1'b0;
    rm_pos         = '0;
    stat           = STAT_OK;
    occupancy_next = occupancy;
    case (op_action)
      ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
        if (full) begin
          stat = STAT_FULL;
        end else begin
          wr_head        = (op_action == ACT_PUSH_HEAD);
          shift_up       = (op_action == ACT_PUSH_TAIL);
          occupancy_next = occupancy + 1'b1;
        end
      end
      ACT_POP_HEAD, ACT_POP_TAIL: begin
        if (empty) begin
          stat = STAT_EMPTY;
        end else begin
          shift_down     = 1'b1;
          rm_pos         = (op_action == ACT_POP_HEAD) ? IDX_W'(occupancy - 1'b1) : '0;
          occupancy_next = occupancy - 1'b1;
        end
      end
      ACT_POP_INDEX: begin
        if (CNT_W'(op_index) >= occupancy) begin
          stat = STAT_EMPTY;
        end else begin
          shift_down     = 1'b1;
          rm_pos         = op_index;
          occupancy_next = occupancy - 1'b1;
        end
      end
      default: begin
        stat = STAT_OK;
      end
    endcase
  end

  assign popped = shift_down ? entries[rm_pos] : '0;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      entries_next[IDX_W'(k)] = entries[IDX_W'(k)];
      if (shift_up) begin
        entries_next[IDX_W'(k)] = (k == 0) ? op_value : entries[IDX_W'(k - 1)];
      end else if (shift_down && (k < DEPTH - 1) && (IDX_W'(k) >= rm_pos)) begin
        entries_next[IDX_W'(k)] = entries[IDX_W'(k + 1)];
      end else if (wr_head && (CNT_W'(k) == occupancy)) begin
        entries_next[IDX_W'(k)] = op_value;
      end
    end
  end

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: controller plus datapath.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   action[2:0], value[31:0], index[3:0]
//   out      out_valid / out_ready value_out[31:0], status[1:0], count[4:0]
//
// Each operation is captured in the idle state and then updates the register
// store in the execute state, where tail pushes and pops shift entries by one place.
// Reset empties the queue at once; no clearing pass is needed.
// The input is taken again while a result still waits in the output register.
// The execute step waits only while the output register is full and stalled.
module double_ended_queue_unit import dqu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            action,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [IDX_W-1:0]      index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] value_out,
  output logic [1:0]            status,
  output logic [CNT_W-1:0]      count
);

  dqu_cmd_t cmd;

  dqu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dqu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .action    (action),
    .value     (value),
    .index     (index),
    .value_out (value_out),
    .status    (status),
    .count     (count)
  );

endmodule
